// ----- src/ps2kt_pkg.sv -----
// Shared types, constants and the set-1 to set-2 scan code table.
package ps2kt_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int ITEM_FIFO_DEPTH = 2;

  localparam logic [7:0]  BREAK_PREFIX   = 8'hF0;
  localparam logic [15:0] INTERVAL_RESET = 16'd1000;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Frame bit positions
  localparam logic [3:0] POS_START      = 4'd0;
  localparam logic [3:0] POS_DATA_FIRST = 4'd1;
  localparam logic [3:0] POS_DATA_LAST  = 4'd8;
  localparam logic [3:0] POS_PARITY     = 4'd9;
  localparam logic [3:0] POS_STOP       = 4'd10;

  // Register byte address bit that selects the register word
  localparam logic REG_BIT_INTERVAL = 1'b0;

  typedef struct packed {
    logic        is_tick;
    logic        key_down;
    logic [7:0]  code;
    logic [31:0] cycle;
  } item_t;

  typedef struct packed {
    logic       prefix;
    logic [7:0] code;
  } entry_t;

  function automatic logic [7:0] set2_of_set1(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h01: r = 8'h76;  8'h02: r = 8'h16;  8'h03: r = 8'h1E;  8'h04: r = 8'h26;
      8'h05: r = 8'h25;  8'h06: r = 8'h2E;  8'h07: r = 8'h36;  8'h08: r = 8'h3D;
      8'h09: r = 8'h3E;  8'h0A: r = 8'h46;  8'h0B: r = 8'h45;  8'h0C: r = 8'h4E;
      8'h0D: r = 8'h55;  8'h0E: r = 8'h66;  8'h0F: r = 8'h0D;  8'h10: r = 8'h15;
      8'h11: r = 8'h1D;  8'h12: r = 8'h24;  8'h13: r = 8'h2D;  8'h14: r = 8'h2C;
      8'h15: r = 8'h35;  8'h16: r = 8'h3C;  8'h17: r = 8'h43;  8'h18: r = 8'h44;
      8'h19: r = 8'h4D;  8'h1A: r = 8'h54;  8'h1B: r = 8'h5B;  8'h1C: r = 8'h5A;
      8'h1D: r = 8'h14;  8'h1E: r = 8'h1C;  8'h1F: r = 8'h1B;  8'h20: r = 8'h23;
      8'h21: r = 8'h2B;  8'h22: r = 8'h34;  8'h23: r = 8'h33;  8'h24: r = 8'h3B;
      8'h25: r = 8'h42;  8'h26: r = 8'h4B;  8'h27: r = 8'h4C;  8'h28: r = 8'h52;
      8'h29: r = 8'h0E;  8'h2A: r = 8'h12;  8'h2B: r = 8'h5D;  8'h2C: r = 8'h1A;
      8'h2D: r = 8'h22;  8'h2E: r = 8'h21;  8'h2F: r = 8'h2A;  8'h30: r = 8'h32;
      8'h31: r = 8'h31;  8'h32: r = 8'h3A;  8'h33: r = 8'h41;  8'h34: r = 8'h49;
      8'h35: r = 8'h4A;  8'h36: r = 8'h59;  8'h37: r = 8'h7C;  8'h38: r = 8'h11;
      8'h39: r = 8'h29;  8'h3A: r = 8'h58;  8'h3B: r = 8'h05;  8'h3C: r = 8'h06;
      8'h3D: r = 8'h04;  8'h3E: r = 8'h0C;  8'h3F: r = 8'h03;  8'h40: r = 8'h0B;
      8'h41: r = 8'h83;  8'h42: r = 8'h0A;  8'h43: r = 8'h01;  8'h44: r = 8'h09;
      8'h45: r = 8'h77;  8'h46: r = 8'h7E;  8'h47: r = 8'h6C;  8'h48: r = 8'h75;
      8'h49: r = 8'h7D;  8'h4A: r = 8'h7B;  8'h4B: r = 8'h6B;  8'h4C: r = 8'h73;
      8'h4D: r = 8'h74;  8'h4E: r = 8'h79;  8'h4F: r = 8'h69;  8'h50: r = 8'h72;
      8'h51: r = 8'h7A;  8'h52: r = 8'h70;  8'h53: r = 8'h71;  8'h57: r = 8'h78;
      8'h58: r = 8'h07;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ps2kt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ps2kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ps2kt_front.sv -----
// Front end: classifies requests and maps key codes from set 1 to set 2.
module ps2kt_front import ps2kt_pkg::*; (
  input  logic        command,
  input  logic        key_down,
  input  logic [7:0]  scan_code,
  input  logic [31:0] cycle_count,
  output item_t       item
);

  always_comb begin
    item.is_tick  = (command == CMD_TICK);
    item.key_down = key_down;
    item.code     = (command == CMD_KEY) ? set2_of_set1(scan_code) : 8'h00;
    item.cycle    = cycle_count;
  end

endmodule

// ----- src/ps2kt_item_fifo.sv -----
// Short queue of classified requests between the front and back ends.
module ps2kt_item_fifo import ps2kt_pkg::*; #(
  parameter int DEPTH = ITEM_FIFO_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ps2kt_back.sv -----
// Back end: code queue, frame serializer, tick timing and result register.
module ps2kt_back import ps2kt_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] bit_interval,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        bit_valid,
  output logic        data_bit,
  output logic        key_accepted
);

  localparam int PTR_W = $clog2(QueueDepth);
  localparam int CNT_W = $clog2(QueueDepth + 1);

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] code_count, code_count_next;
  logic [3:0]       bit_position, bit_position_next;
  logic             second_code, second_code_next;
  logic [31:0]      last_cycle, last_cycle_next;
  logic             drive_phase, drive_phase_next;
  logic             byp_valid;
  entry_t           byp_data;

  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  entry_t           head_entry;
  logic [7:0]       frame_code;
  logic             frame_bit;
  logic [1:0]       need;
  logic             fits;
  logic [31:0]      diff;
  logic             due;
  logic             take;
  logic             res_valid, res_data, res_acc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  ps2kt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QueueDepth)
  ) u_code_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(ram_wdata),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  always_comb begin
    take       = item_valid && (!out_valid || !out_stall);
    item_pop   = take;
    head_entry = byp_valid ? byp_data : ram_rdata;
    frame_code = (head_entry.prefix && !second_code) ? BREAK_PREFIX : head_entry.code;

    case (bit_position) inside
      POS_START:                      frame_bit = 1'b0;
      [POS_DATA_FIRST:POS_DATA_LAST]: frame_bit = frame_code[3'(bit_position - 4'd1)];
      POS_PARITY:                     frame_bit = ~^frame_code;
      default:                        frame_bit = 1'b1;
    endcase

    need = item.key_down ? 2'd1 : 2'd2;
    fits = ({1'b0, code_count} + (CNT_W + 1)'(need)) <= (CNT_W + 1)'(QueueDepth);
    diff = item.cycle - last_cycle;
    due  = diff > {16'b0, bit_interval};

    head_next         = head;
    tail_next         = tail;
    code_count_next   = code_count;
    bit_position_next = bit_position;
    second_code_next  = second_code;
    last_cycle_next   = last_cycle;
    drive_phase_next  = drive_phase;
    ram_we            = 1'b0;
    ram_wdata.prefix  = ~item.key_down;
    ram_wdata.code    = item.code;
    res_valid         = 1'b0;
    res_data          = 1'b0;
    res_acc           = 1'b0;

    if (take) begin
      if (!item.is_tick) begin
        if (fits) begin
          ram_we          = 1'b1;
          tail_next       = ptr_inc(tail);
          code_count_next = code_count + CNT_W'(need);
          res_acc         = 1'b1;
        end
      end else if (!(code_count == '0 && drive_phase)) begin
        if (due) begin
          last_cycle_next  = item.cycle;
          drive_phase_next = ~drive_phase;
          if (drive_phase) begin
            res_valid = 1'b1;
            res_data  = frame_bit;
            if (bit_position >= POS_STOP) begin
              // Frame done: drop one code; a prefixed entry stays for its code frame
              bit_position_next = POS_START;
              code_count_next   = code_count - 1'b1;
              if (head_entry.prefix && !second_code) begin
                second_code_next = 1'b1;
              end else begin
                second_code_next = 1'b0;
                head_next        = ptr_inc(head);
              end
            end else begin
              bit_position_next = bit_position + 4'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      code_count   <= '0;
      bit_position <= POS_START;
      second_code  <= 1'b0;
      last_cycle   <= '0;
      drive_phase  <= 1'b1;
      byp_valid    <= 1'b0;
    end else begin
      head         <= head_next;
      tail         <= tail_next;
      code_count   <= code_count_next;
      bit_position <= bit_position_next;
      second_code  <= second_code_next;
      last_cycle   <= last_cycle_next;
      drive_phase  <= drive_phase_next;
      // Forward a write that lands on the address being read
      byp_valid    <= ram_we && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bit_valid    <= res_valid;
      data_bit     <= res_data;
      key_accepted <= res_acc;
    end
  end

endmodule

// ----- src/ps2_keyboard_frame_transmitter.sv -----
// Top level of the PS/2 keyboard frame transmitter.
// Takes one request per clock while in_stall is low and returns exactly one result per
// request, in order, via the request queue and result register. Key events are mapped
// from set 1 to set 2 and stored in a code queue of QueueDepth entries (a release
// stores the code with an 0xF0 prefix and counts as two codes; an event that does
// not fit is dropped whole). Tick requests carry a cycle count; once the wrapped
// difference to the last due tick exceeds bit_interval (register at byte
// address 0, reset 1000) the phase toggles, and on the drive phase one bit of the
// 11-bit frame (start, eight data bits LSB first, odd parity, stop) comes out.
// A two-entry request queue sits between the classifying front end and the back
// end; while out_stall holds a waiting result, the back end takes no new request.
module ps2_keyboard_frame_transmitter import ps2kt_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic        key_down,
  input  logic [7:0]  scan_code,
  input  logic [31:0] cycle_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        bit_valid,
  output logic        data_bit,
  output logic        key_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] bit_interval;
  item_t       front_item;
  item_t       back_item;
  logic        fifo_full;
  logic        fifo_empty;
  logic        item_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIT_INTERVAL) ? {16'b0, bit_interval} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_interval <= INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_INTERVAL) begin
      bit_interval <= pwdata[15:0];
    end
  end

  assign in_stall = fifo_full;

  ps2kt_front u_front (
    .command    (command),
    .key_down   (key_down),
    .scan_code  (scan_code),
    .cycle_count(cycle_count),
    .item       (front_item)
  );

  ps2kt_item_fifo #(
    .DEPTH(ITEM_FIFO_DEPTH)
  ) u_item_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && !fifo_full),
    .push_item(front_item),
    .full     (fifo_full),
    .pop      (item_pop),
    .pop_item (back_item),
    .empty    (fifo_empty)
  );

  ps2kt_back #(
    .QueueDepth(QueueDepth)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bit_interval(bit_interval),
    .item_valid  (!fifo_empty),
    .item        (back_item),
    .item_pop    (item_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bit_valid   (bit_valid),
    .data_bit    (data_bit),
    .key_accepted(key_accepted)
  );

endmodule
